/* hw/rtl/ffha_pkg.sv */
// Shared types for the first-fit heap manager.
// Controller states and the command/status bundles between controller and datapath.
// No dependencies.
package ffha_pkg;

	localparam logic OP_ALLOC  = 1'b0;
	localparam logic OP_FREE   = 1'b1;
	localparam logic STAT_DONE = 1'b0;
	localparam logic STAT_OOH  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISP,
		ST_A_CHK,
		ST_A_EV,
		ST_A_APP,
		ST_F_WR,
		ST_M_CHK,
		ST_M_EV1,
		ST_M_EV2
	} state_t;

	typedef enum logic [1:0] {
		RS_CUR,
		RS_NXT,
		RS_FREE
	} rsel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_GRANT,
		WR_APPEND,
		WR_FREE,
		WR_MERGE
	} wop_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_GRANT,
		RES_APPEND,
		RES_ZERO,
		RES_OOH
	} res_t;

	typedef struct packed {
		logic  load;
		logic  rd_en;
		rsel_t rsel;
		wop_t  wop;
		logic  cur_zero;
		logic  cur_step;
		logic  cur_skip;
		logic  sz_save;
		logic  top_add;
		logic  fcnt_inc;
		logic  fcnt_clr;
		res_t  res;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic cur_lt_top;
		logic sz_zero;
		logic rd_avail;
		logic fit;
		logic app_ok;
		logic free_ok;
		logic merge_due;
		logic nxt_lt_top;
	} sts_t;

endpackage

/* hw/rtl/first_fit_heap_allocator.sv */
// First-fit heap manager, top level.
// Instantiates ffha_ctrl and ffha_dp; depends on ffha_pkg.
//
// Usage:
//   Command channel: drive opcode, request_bytes, block_address and raise
//   start; the item is taken at an edge where start is high and busy is low.
//   busy stays high until the result has been issued.
//   Result: done pulses for one cycle with address and status. The receiver
//   cannot stall; the result must be captured in that cycle.
//   Config: cfg_valid/cfg_ready write coalesce_period (cfg_ready is always
//   high); write only while busy is low.
// Timing: the walk reads one header at a time from the header memory (one
//   read and one write port); each block passes ST_A_CHK then ST_A_EV. busy
//   stays high through the walk and the grant or append; a free holds it in
//   ST_DISP and ST_F_WR (ST_DISP alone when ignored), then on a merge pass in
//   ST_M_CHK, ST_M_EV1 and ST_M_EV2 per block. done is registered from the result.
// Reset: heap top, free count and results clear, period returns to 5. The
//   header memory is not cleared and needs no clearing pass.
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES   = 4096,
	parameter int HEADER_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [12:0] request_bytes,
	input  logic [11:0] block_address,
	output logic        done,
	output logic [11:0] address,
	output logic        status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	ffha_pkg::cmd_t cmd;
	ffha_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	ffha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	ffha_dp #(
		.HEAP_BYTES   (HEAP_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (opcode),
		.request_bytes (request_bytes),
		.block_address (block_address),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.done          (done),
		.address       (address),
		.status        (status)
	);

endmodule

/* hw/rtl/ffha_ctrl.sv */
// Controller state machine for the first-fit heap manager.
// Sequences allocate walks, frees and merge passes; drives ffha_pkg::cmd_t.
// Depends on ffha_pkg.
module ffha_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ffha_pkg::sts_t sts,
	output ffha_pkg::cmd_t cmd,
	output logic           busy
);

	ffha_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffha_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ffha_pkg::ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.rsel     = ffha_pkg::RS_CUR;
		cmd.wop      = ffha_pkg::WR_NONE;
		cmd.res      = ffha_pkg::RES_NONE;
		case (state_q)
			ffha_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ffha_pkg::ST_DISP;
				end
			end
			ffha_pkg::ST_DISP: begin
				if (sts.op == ffha_pkg::OP_ALLOC) begin
					cmd.cur_zero = 1'b1;
					state_d      = ffha_pkg::ST_A_CHK;
				end else if (sts.free_ok) begin
					cmd.rd_en = 1'b1;
					cmd.rsel  = ffha_pkg::RS_FREE;
					state_d   = ffha_pkg::ST_F_WR;
				end else begin
					cmd.res = ffha_pkg::RES_ZERO;
					state_d = ffha_pkg::ST_IDLE;
				end
			end
			ffha_pkg::ST_A_CHK: begin
				if (sts.cur_lt_top) begin
					cmd.rd_en = 1'b1;
					state_d   = ffha_pkg::ST_A_EV;
				end else begin
					state_d = ffha_pkg::ST_A_APP;
				end
			end
			ffha_pkg::ST_A_EV: begin
				if (sts.sz_zero) begin
					state_d = ffha_pkg::ST_A_APP;
				end else if (sts.fit) begin
					cmd.wop = ffha_pkg::WR_GRANT;
					cmd.res = ffha_pkg::RES_GRANT;
					state_d = ffha_pkg::ST_IDLE;
				end else begin
					cmd.cur_step = 1'b1;
					state_d      = ffha_pkg::ST_A_CHK;
				end
			end
			ffha_pkg::ST_A_APP: begin
				if (sts.app_ok) begin
					cmd.wop     = ffha_pkg::WR_APPEND;
					cmd.res     = ffha_pkg::RES_APPEND;
					cmd.top_add = 1'b1;
				end else begin
					cmd.res = ffha_pkg::RES_OOH;
				end
				state_d = ffha_pkg::ST_IDLE;
			end
			ffha_pkg::ST_F_WR: begin
				cmd.wop = ffha_pkg::WR_FREE;
				if (sts.merge_due) begin
					cmd.fcnt_clr = 1'b1;
					cmd.cur_zero = 1'b1;
					state_d      = ffha_pkg::ST_M_CHK;
				end else begin
					cmd.fcnt_inc = 1'b1;
					cmd.res      = ffha_pkg::RES_ZERO;
					state_d      = ffha_pkg::ST_IDLE;
				end
			end
			ffha_pkg::ST_M_CHK: begin
				if (sts.cur_lt_top) begin
					cmd.rd_en = 1'b1;
					state_d   = ffha_pkg::ST_M_EV1;
				end else begin
					cmd.res = ffha_pkg::RES_ZERO;
					state_d = ffha_pkg::ST_IDLE;
				end
			end
			ffha_pkg::ST_M_EV1: begin
				if (sts.sz_zero) begin
					cmd.res = ffha_pkg::RES_ZERO;
					state_d = ffha_pkg::ST_IDLE;
				end else if (sts.rd_avail && sts.nxt_lt_top) begin
					cmd.sz_save = 1'b1;
					cmd.rd_en   = 1'b1;
					cmd.rsel    = ffha_pkg::RS_NXT;
					state_d     = ffha_pkg::ST_M_EV2;
				end else begin
					cmd.cur_step = 1'b1;
					state_d      = ffha_pkg::ST_M_CHK;
				end
			end
			ffha_pkg::ST_M_EV2: begin
				if (sts.sz_zero) begin
					cmd.res = ffha_pkg::RES_ZERO;
					state_d = ffha_pkg::ST_IDLE;
				end else if (sts.rd_avail) begin
					cmd.wop = ffha_pkg::WR_MERGE;
					state_d = ffha_pkg::ST_M_CHK;
				end else begin
					cmd.cur_skip = 1'b1;
					state_d      = ffha_pkg::ST_M_CHK;
				end
			end
			default: begin
				state_d = ffha_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/ffha_dp.sv */
// Datapath for the first-fit heap manager: header memory, walk pointer,
// heap top, free counter, merge period register and result registers.
// Depends on ffha_pkg.
module ffha_dp #(
	parameter int HEAP_BYTES   = 4096,
	parameter int HEADER_BYTES = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ffha_pkg::cmd_t cmd,
	output ffha_pkg::sts_t sts,
	input  logic           opcode,
	input  logic [12:0]    request_bytes,
	input  logic [11:0]    block_address,
	input  logic           cfg_valid,
	input  logic [7:0]     cfg_data,
	output logic           done,
	output logic [11:0]    address,
	output logic           status
);

	localparam int AW = $clog2(HEAP_BYTES);
	localparam int SW = $clog2(HEAP_BYTES + 1);
	localparam int XW = ((SW > 13) ? SW : 13) + 2;
	localparam logic [XW-1:0] HEAP_X = XW'(HEAP_BYTES);
	localparam logic [XW-1:0] HDR_X  = XW'(HEADER_BYTES);

	logic [SW:0]    mem [HEAP_BYTES];
	logic [SW:0]    rd_q;
	logic [AW-1:0]  rd_addr, wr_addr;
	logic [SW:0]    wr_data;
	logic           wr_en;

	logic           op_q;
	logic [XW-1:0]  need_q, ua_q, cur_q, sz_q, top_q;
	logic [7:0]     fcnt_q, period_q;

	logic [XW-1:0]  rd_size, nxt, h, period_x;
	logic [7:0]     fcnt_p1, period_eff;

	assign rd_size = XW'(rd_q[SW-1:0]);
	assign nxt     = cur_q + rd_size;
	assign h       = ua_q - HDR_X;
	assign fcnt_p1 = fcnt_q + 8'd1;
	assign period_eff = (period_q == 8'd0) ? 8'd1 : period_q;
	assign period_x   = XW'(period_eff);

	always_comb begin
		sts.op         = op_q;
		sts.cur_lt_top = cur_q < top_q;
		sts.sz_zero    = rd_size == '0;
		sts.rd_avail   = rd_q[SW];
		sts.fit        = rd_q[SW] && (rd_size >= need_q) && (cur_q + HDR_X < HEAP_X);
		sts.app_ok     = (top_q + need_q <= HEAP_X) && (top_q + HDR_X < HEAP_X);
		sts.free_ok    = (ua_q >= HDR_X) && (h < top_q) && (h < HEAP_X);
		sts.merge_due  = XW'(fcnt_p1) >= period_x;
		sts.nxt_lt_top = nxt < top_q;
	end

	always_comb begin
		case (cmd.rsel)
			ffha_pkg::RS_NXT:  rd_addr = nxt[AW-1:0];
			ffha_pkg::RS_FREE: rd_addr = h[AW-1:0];
			default:           rd_addr = cur_q[AW-1:0];
		endcase
		wr_en   = 1'b1;
		wr_addr = cur_q[AW-1:0];
		wr_data = rd_q;
		case (cmd.wop)
			ffha_pkg::WR_GRANT: wr_data = {1'b0, rd_q[SW-1:0]};
			ffha_pkg::WR_APPEND: begin
				wr_addr = top_q[AW-1:0];
				wr_data = {1'b0, need_q[SW-1:0]};
			end
			ffha_pkg::WR_FREE: begin
				wr_addr = h[AW-1:0];
				wr_data = {1'b1, rd_q[SW-1:0]};
			end
			ffha_pkg::WR_MERGE: begin
				wr_data = {1'b1, sz_q[SW-1:0] + rd_q[SW-1:0]};
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			need_q <= XW'(request_bytes) + HDR_X;
			ua_q   <= XW'(block_address);
		end
		if (cmd.cur_zero) begin
			cur_q <= '0;
		end else if (cmd.cur_step) begin
			cur_q <= nxt;
		end else if (cmd.cur_skip) begin
			cur_q <= cur_q + sz_q + rd_size;
		end
		if (cmd.sz_save) begin
			sz_q <= rd_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q    <= '0;
			fcnt_q   <= '0;
			period_q <= 8'd5;
			done     <= 1'b0;
			address  <= '0;
			status   <= ffha_pkg::STAT_DONE;
		end else begin
			if (cmd.top_add) begin
				top_q <= top_q + need_q;
			end
			if (cmd.fcnt_clr) begin
				fcnt_q <= '0;
			end else if (cmd.fcnt_inc) begin
				fcnt_q <= fcnt_p1;
			end
			if (cfg_valid) begin
				period_q <= cfg_data;
			end
			done <= (cmd.res != ffha_pkg::RES_NONE);
			case (cmd.res)
				ffha_pkg::RES_GRANT: begin
					address <= 12'(cur_q + HDR_X);
					status  <= ffha_pkg::STAT_DONE;
				end
				ffha_pkg::RES_APPEND: begin
					address <= 12'(top_q + HDR_X);
					status  <= ffha_pkg::STAT_DONE;
				end
				ffha_pkg::RES_OOH: begin
					address <= '0;
					status  <= ffha_pkg::STAT_OOH;
				end
				ffha_pkg::RES_ZERO: begin
					address <= '0;
					status  <= ffha_pkg::STAT_DONE;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* test/first_fit_heap_allocator_tb.sv */
// Self-checking testbench for the first-fit heap manager (first_fit_heap_allocator).
// A scoreboard class mirrors the block list, heap top and merge counter to predict each result.
// Depends on ffha_pkg and the RTL only.
module first_fit_heap_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HEAP = 4096;
	localparam int HDR = 8;
	localparam int WD_LIMIT = 40000;
	localparam logic OP_ALLOC = ffha_pkg::OP_ALLOC;
	localparam logic OP_FREE = ffha_pkg::OP_FREE;
	localparam logic ST_DONE = ffha_pkg::STAT_DONE;
	localparam logic ST_OOH = ffha_pkg::STAT_OOH;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic opcode = OP_ALLOC;
	logic [12:0] request_bytes = '0;
	logic [11:0] block_address = '0;
	logic done;
	logic [11:0] address;
	logic status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = '0;

	int errors = 0;
	int idle_pct = 0;
	int wd_count = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	first_fit_heap_allocator u_top (.*);

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	typedef struct {
		logic [11:0] addr;
		logic st;
	} grant_t;

	class heap_scoreboard;
		bit avail[HEAP];
		int unsigned blk_sz[HEAP];
		int unsigned top;
		int unsigned frees;
		logic [7:0] period;
		int unsigned hdrs[$];
		grant_t pending[$];

		function new();
			top = 0;
			frees = 0;
			period = 8'd5;
		endfunction

		function void merge_blocks();
			int unsigned cur, sz, nxt, nsz;
			cur = 0;
			frees = 0;
			while (cur < top) begin
				sz = blk_sz[cur];
				nxt = cur + sz;
				if (sz == 0)
					break;
				if (avail[cur] && nxt < top) begin
					nsz = blk_sz[nxt];
					if (nsz == 0)
						break;
					if (avail[nxt])
						blk_sz[cur] = sz + nsz;
					else
						cur = nxt + nsz;
				end else begin
					cur = nxt;
				end
			end
		endfunction

		function void note_item(logic op, logic [12:0] req, logic [11:0] uaddr);
			grant_t g;
			int unsigned need, cur, h, per;
			bit found;
			g.addr = '0;
			g.st = ST_DONE;
			if (op == OP_ALLOC) begin
				need = req + HDR;
				cur = 0;
				found = 0;
				while (cur < top) begin
					if (blk_sz[cur] == 0)
						break;
					if (avail[cur] && blk_sz[cur] >= need && cur + HDR < HEAP) begin
						avail[cur] = 0;
						g.addr = 12'(cur + HDR);
						found = 1;
						break;
					end
					cur += blk_sz[cur];
				end
				if (!found) begin
					if (top + need <= HEAP && top + HDR < HEAP) begin
						avail[top] = 0;
						blk_sz[top] = need;
						hdrs.push_back(top);
						g.addr = 12'(top + HDR);
						top += need;
					end else begin
						g.st = ST_OOH;
					end
				end
			end else if (uaddr >= HDR) begin
				h = uaddr - HDR;
				if (h < top) begin
					per = (period == 0) ? 1 : period;
					avail[h] = 1;
					frees = (frees + 1) & 8'hFF;
					if (frees >= per)
						merge_blocks();
				end
			end
			pending.push_back(g);
		endfunction

		task check_result(logic [11:0] addr, logic st);
			grant_t g;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected result addr=%0d status=%0d", addr, st));
				return;
			end
			g = pending.pop_front();
			if (addr !== g.addr)
				report_mismatch($sformatf("address %0d, expected %0d", addr, g.addr));
			if (st !== g.st)
				report_mismatch($sformatf("status %0d, expected %0d", st, g.st));
		endtask
	endclass

	heap_scoreboard sb = new();

	always @(posedge clk)
		if (done)
			sb.check_result(address, status);

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			wd_count <= 0;
		else
			wd_count <= wd_count + 1;
		if (wd_count >= WD_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// start stays high across back-to-back items; lowered only when the sender idles
	task automatic send_item(input logic op, input logic [12:0] req, input logic [11:0] uaddr);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		opcode = op;
		request_bytes = req;
		block_address = uaddr;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy);
		sb.note_item(op, req, uaddr);
		@(negedge clk);
	endtask

	task automatic drain();
		start = 1'b0;
		while (sb.pending.size() != 0 || busy)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_period(input logic [7:0] val);
		drain();
		cfg_data = val;
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.period = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic random_item();
		logic [12:0] req;
		int unsigned r, h;
		req = 13'($urandom);
		if ($urandom_range(99) < 55 || sb.hdrs.size() == 0) begin
			r = $urandom_range(99);
			if (r < 70)
				req = 13'($urandom_range(48));
			else if (r < 95)
				req = 13'($urandom_range(400));
			else
				req = 13'($urandom_range(4096));
			send_item(OP_ALLOC, req, 12'($urandom));
		end else if ($urandom_range(99) < 82) begin
			h = sb.hdrs[$urandom_range(sb.hdrs.size() - 1)];
			send_item(OP_FREE, req, 12'(h + HDR));
		end else if ($urandom_range(1) == 0 || sb.top + HDR > HEAP - 1) begin
			send_item(OP_FREE, req, 12'($urandom_range(HDR - 1)));
		end else begin
			send_item(OP_FREE, req, 12'($urandom_range(HEAP - 1, sb.top + HDR)));
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, out of heap, bad frees, merge at reset period
		send_item(OP_ALLOC, 13'd0, 12'hFFF);
		send_item(OP_ALLOC, 13'd4096, 12'd0);
		send_item(OP_ALLOC, 13'd16, 12'd0);
		send_item(OP_ALLOC, 13'd16, 12'd0);
		send_item(OP_ALLOC, 13'd16, 12'd0);
		send_item(OP_ALLOC, 13'd40, 12'd0);
		send_item(OP_FREE, 13'h1FFF, 12'd0);
		send_item(OP_FREE, 13'd0, 12'd7);
		send_item(OP_FREE, 13'd0, 12'hFFF);
		send_item(OP_FREE, 13'd0, 12'd16);
		send_item(OP_FREE, 13'd0, 12'd40);
		send_item(OP_FREE, 13'd0, 12'd64);
		send_item(OP_FREE, 13'd0, 12'd8);
		send_item(OP_FREE, 13'd0, 12'd16);
		send_item(OP_ALLOC, 13'd50, 12'd0);
		send_item(OP_ALLOC, 13'd0, 12'd0);
		send_item(OP_ALLOC, 13'd3900, 12'd0);
		send_item(OP_ALLOC, 13'd4000, 12'd0);
		send_item(OP_FREE, 13'd0, 12'd88);
		send_item(OP_ALLOC, 13'd3000, 12'd0);

		write_period(8'd1);
		idle_pct = 27;
		repeat (210) random_item();
		write_period(8'd255);
		idle_pct = 85;
		repeat (210) random_item();
		write_period(8'd0);
		idle_pct = 0;
		repeat (110) random_item();
		write_period(8'($urandom_range(254, 2)));
		repeat (110) random_item();

		drain();
		repeat (40) @(negedge clk);
		if (errors == 0 && sb.pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			if (sb.pending.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
